[hdl/plcm_pkg.sv]
// Package for the piecewise-linear color map block.
// Holds the control point tables, the map directory and register codes.
// Depends on nothing; used by the top level of the block.
package plcm_pkg;

    localparam int NUM_MAPS   = 8;
    localparam int NUM_POINTS = 43;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_INDEX_W = 3;
    localparam int COUNT_W    = 13;
    localparam int REPEAT_W   = 5;
    localparam int GAIN_W     = 16;
    localparam int OFFSET_W   = 13;
    localparam int GAIN_FRAC  = 12;
    localparam int DEN_W      = COUNT_W + GAIN_FRAC;
    localparam int COLOR_W    = 8;
    localparam int POINT_W    = 6;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_MAP_SELECT   = 3'd0,
        REG_COLOR_COUNT  = 3'd1,
        REG_REPEAT_COUNT = 3'd2,
        REG_GAIN         = 3'd3,
        REG_INDEX_OFFSET = 3'd4
    } cfg_reg_t;

    typedef logic [3*COLOR_W-1:0] rgb_t;

    localparam logic [6:0] PT_PCT [NUM_POINTS] = '{
        7'd0, 7'd100,
        7'd0, 7'd10, 7'd35, 7'd50, 7'd65, 7'd90, 7'd100,
        7'd0, 7'd25, 7'd50, 7'd75, 7'd100,
        7'd0, 7'd10, 7'd30, 7'd50, 7'd70, 7'd90, 7'd100,
        7'd0, 7'd10, 7'd30, 7'd45, 7'd60, 7'd100,
        7'd0, 7'd10, 7'd20, 7'd35, 7'd50, 7'd60, 7'd90, 7'd100,
        7'd0, 7'd50, 7'd100,
        7'd0, 7'd5, 7'd50, 7'd95, 7'd100
    };

    localparam rgb_t PT_RGB [NUM_POINTS] = '{
        24'h000000, 24'hFFFFFF,
        24'h00007F, 24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000,
        24'h7F0000,
        24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000,
        24'h000000, 24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000,
        24'hFFFFFF,
        24'hFF00FF, 24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00, 24'hFF0000,
        24'h000000, 24'h960096, 24'h0000FF, 24'h00FFFF, 24'h00FF00, 24'hFFFF00,
        24'hFF0000, 24'hFFFFFF,
        24'h0000FF, 24'hFF00FF, 24'hFFFF00,
        24'h000000, 24'h0000FF, 24'hFF00FF, 24'hFFFF00, 24'hFFFFFF
    };

    localparam logic [POINT_W-1:0] MAP_FIRST [NUM_MAPS] = '{
        6'd0, 6'd2, 6'd9, 6'd14, 6'd21, 6'd27, 6'd35, 6'd38
    };
    localparam logic [3:0] MAP_LEN [NUM_MAPS] = '{
        4'd2, 4'd7, 4'd5, 4'd7, 4'd6, 4'd8, 4'd3, 4'd5
    };

endpackage

[hdl/plcm_div.sv]
// Pipelined restoring divider, one quotient bit per register stage.
// Several lanes share one divisor; a side word travels with each item.
// Depends on nothing outside this file.
module plcm_div #(
    parameter int LANES  = 1,
    parameter int DW     = 8,
    parameter int STEPS  = 8,
    parameter int SIDE_W = 1
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DW-1:0]     in_rem [LANES],
    input  logic [STEPS-1:0]  in_bits [LANES],
    input  logic [DW-1:0]     in_divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    output logic [STEPS-1:0]  out_quot [LANES],
    output logic [SIDE_W-1:0] out_side
);

    logic [DW-1:0]     rem_reg   [STEPS][LANES];
    logic [DW-1:0]     rem_next  [STEPS][LANES];
    logic [STEPS-1:0]  bits_reg  [STEPS][LANES];
    logic [STEPS-1:0]  bits_next [STEPS][LANES];
    logic [STEPS-1:0]  quot_reg  [STEPS][LANES];
    logic [STEPS-1:0]  quot_next [STEPS][LANES];
    logic [DW-1:0]     div_reg   [STEPS];
    logic [DW-1:0]     div_next  [STEPS];
    logic [SIDE_W-1:0] side_reg  [STEPS];
    logic [SIDE_W-1:0] side_next [STEPS];
    logic [STEPS-1:0]  valid_reg;
    logic [STEPS-1:0]  valid_next;

    always_comb
    begin
        logic [DW-1:0]    src_rem;
        logic [STEPS-1:0] src_bits;
        logic [STEPS-1:0] src_quot;
        logic [DW-1:0]    src_div;
        logic [DW:0]      trial;
        logic [DW:0]      diff;
        logic             ge;
        for (int k = 0; k < STEPS; k++)
        begin
            src_div      = (k == 0) ? in_divisor : div_reg[k-1];
            div_next[k]  = src_div;
            side_next[k] = (k == 0) ? in_side : side_reg[k-1];
            valid_next[k] = (k == 0) ? in_valid : valid_reg[k-1];
            for (int l = 0; l < LANES; l++)
            begin
                src_rem  = (k == 0) ? in_rem[l]  : rem_reg[k-1][l];
                src_bits = (k == 0) ? in_bits[l] : bits_reg[k-1][l];
                src_quot = (k == 0) ? '0         : quot_reg[k-1][l];
                trial = {src_rem, src_bits[STEPS-1]};
                diff  = trial - {1'b0, src_div};
                ge    = (trial >= {1'b0, src_div});
                rem_next[k][l]  = ge ? diff[DW-1:0] : trial[DW-1:0];
                bits_next[k][l] = src_bits << 1;
                quot_next[k][l] = {src_quot[STEPS-2:0], ge};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int k = 0; k < STEPS; k++)
            begin
                div_reg[k]  <= div_next[k];
                side_reg[k] <= side_next[k];
                for (int l = 0; l < LANES; l++)
                begin
                    rem_reg[k][l]  <= rem_next[k][l];
                    bits_reg[k][l] <= bits_next[k][l];
                    quot_reg[k][l] <= quot_next[k][l];
                end
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];
    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            out_quot[l] = quot_reg[STEPS-1][l];
        end
    end

endmodule

[hdl/piecewise_linear_color_map.sv]
// Top level of the piecewise-linear color map: registers, position pipeline,
// segment select and interpolation. Depends on plcm_pkg and plcm_div.
//
//   channel   signals                          direction
//   input     in_valid in_ready entry_index    in
//   output    out_valid out_ready red green blue   out
//   config    cfg_we cfg_index cfg_data        in
//
// One word enters per cycle unless the output stalls; the position divider has
// 5 + RATIO_FRAC_BITS stages and the interpolation divider 8.
// Reset clears only the valid bits and loads the register defaults.
// A stalled output word freezes the whole pipeline; nothing is lost or repeated.
module piecewise_linear_color_map #(
    parameter int INDEX_BITS      = 12,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [2:0]            cfg_index,
    input  logic [15:0]           cfg_data,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic [INDEX_BITS-1:0] entry_index,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [7:0]            red,
    output logic [7:0]            green,
    output logic [7:0]            blue
);
    import plcm_pkg::*;

    localparam int F     = RATIO_FRAC_BITS;
    localparam int SXW   = ((INDEX_BITS > OFFSET_W) ? INDEX_BITS : OFFSET_W) + 2;
    localparam int MW    = SXW - 1;
    localparam int PROD_W = GAIN_W + MW;
    localparam int PW    = PROD_W + REPEAT_W;
    localparam int RD_W  = REPEAT_W + DEN_W;
    localparam int Q1    = REPEAT_W + F;
    localparam int PA_W  = COLOR_W + F + 1;
    localparam int N_W   = COLOR_W + F;

    typedef logic [F:0] ratio_arr_t [NUM_POINTS];

    function automatic ratio_arr_t build_ratios();
        ratio_arr_t r;
        longint v;
        for (int p = 0; p < NUM_POINTS; p++)
        begin
            v = ((longint'(PT_PCT[p]) << F) + 50) / 100;
            r[p] = v[F:0];
        end
        return r;
    endfunction

    localparam ratio_arr_t RATIO = build_ratios();

    // Configuration registers
    logic [2:0]          map_select_reg;
    logic [COUNT_W-1:0]  color_count_reg;
    logic [REPEAT_W-1:0] repeat_count_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [OFFSET_W-1:0] index_offset_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            map_select_reg   <= 3'd0;
            color_count_reg  <= COUNT_W'(256);
            repeat_count_reg <= REPEAT_W'(1);
            gain_reg         <= GAIN_W'(4096);
            index_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_MAP_SELECT:   map_select_reg   <= cfg_data[2:0];
                REG_COLOR_COUNT:  color_count_reg  <= cfg_data[COUNT_W-1:0];
                REG_REPEAT_COUNT: repeat_count_reg <= cfg_data[REPEAT_W-1:0];
                REG_GAIN:         gain_reg         <= cfg_data[GAIN_W-1:0];
                REG_INDEX_OFFSET: index_offset_reg <= cfg_data[OFFSET_W-1:0];
                default:          ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Stage A: offset and special cases
    logic                  a_valid_reg;
    logic signed [SXW-1:0] a_s_reg;
    logic                  a_black_reg;
    logic signed [SXW-1:0] a_s_next;

    assign a_s_next = signed'({{(SXW-INDEX_BITS){1'b0}}, entry_index})
                    + signed'({{(SXW-OFFSET_W){index_offset_reg[OFFSET_W-1]}},
                               index_offset_reg});

    // Stage B: gain times position
    logic              b_valid_reg;
    logic [PROD_W-1:0] b_prod_reg;
    logic              b_black_reg;
    logic              b_neg_reg;

    // Stage C: times repeat count, and the end-of-range bound
    logic            c_valid_reg;
    logic [PW-1:0]   c_p_reg;
    logic [RD_W-1:0] c_rd_reg;
    logic            c_black_reg;
    logic            c_neg_reg;

    logic [DEN_W-1:0] den;
    assign den = {color_count_reg, {GAIN_FRAC{1'b0}}};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_s_reg     <= a_s_next;
            a_black_reg <= (gain_reg == '0) || (color_count_reg == '0)
                        || (repeat_count_reg == '0);
            b_prod_reg  <= gain_reg * a_s_reg[MW-1:0];
            b_black_reg <= a_black_reg;
            b_neg_reg   <= a_s_reg[SXW-1];
            c_p_reg     <= b_prod_reg * repeat_count_reg;
            c_rd_reg    <= repeat_count_reg * den;
            c_black_reg <= b_black_reg;
            c_neg_reg   <= b_neg_reg;
        end
    end

    // Position divider: floor(P * 2^F / D), remainder seeded with P / 32
    logic [DEN_W-1:0] d1_rem  [1];
    logic [Q1-1:0]    d1_bits [1];
    logic [Q1-1:0]    d1_quot [1];
    logic [2:0]       d1_side_in;
    logic [2:0]       d1_side;
    logic             d1_valid;
    logic             c_hi;

    assign c_hi       = (c_p_reg >= PW'(c_rd_reg));
    assign d1_rem[0]  = c_p_reg[DEN_W+REPEAT_W-1:REPEAT_W];
    assign d1_bits[0] = {c_p_reg[REPEAT_W-1:0], {F{1'b0}}};
    assign d1_side_in = {c_black_reg, c_neg_reg, c_hi};

    plcm_div #(
        .LANES(1), .DW(DEN_W), .STEPS(Q1), .SIDE_W(3)
    ) u_pos_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(c_valid_reg), .in_rem(d1_rem), .in_bits(d1_bits),
        .in_divisor(den), .in_side(d1_side_in),
        .out_valid(d1_valid), .out_quot(d1_quot), .out_side(d1_side)
    );

    // Stage E: segment select
    logic [F:0]         f_pos;
    logic [POINT_W-1:0] first;
    logic [3:0]         n_pts;
    logic [POINT_W-1:0] seg;
    logic [POINT_W-1:0] pidx;
    logic [F:0]         r0;
    logic [F:0]         r1;
    rgb_t               ovr_col;

    assign f_pos = {1'b0, d1_quot[0][F-1:0]};
    assign first = MAP_FIRST[map_select_reg];
    assign n_pts = MAP_LEN[map_select_reg];

    always_comb
    begin
        seg = first;
        for (int k = 1; k < 7; k++)
        begin
            pidx = first + POINT_W'(k);
            if ((k + 1 < int'(n_pts)) && (int'(pidx) < NUM_POINTS)
                && (f_pos >= RATIO[pidx]))
            begin
                seg = pidx;
            end
        end
        pidx = first + POINT_W'(n_pts) - POINT_W'(1);
        if (d1_side[2])
            ovr_col = '0;
        else if (d1_side[1])
            ovr_col = PT_RGB[first];
        else
            ovr_col = PT_RGB[pidx];
    end

    assign r0 = RATIO[seg];
    assign r1 = RATIO[seg + POINT_W'(1)];

    logic       e_valid_reg;
    logic [F:0] e_t_reg;
    logic [F:0] e_d_reg;
    rgb_t       e_a_reg;
    rgb_t       e_b_reg;
    logic       e_ovr_reg;
    rgb_t       e_ovr_col_reg;

    // Stage F: channel products
    logic          f_valid_reg;
    logic [PA_W-1:0] f_pa_reg [3];
    logic [PA_W-1:0] f_pb_reg [3];
    logic [F:0]    f_d_reg;
    logic          f_ovr_reg;
    rgb_t          f_ovr_col_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= d1_valid;
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_t_reg       <= f_pos - r0;
            e_d_reg       <= r1 - r0;
            e_a_reg       <= PT_RGB[seg];
            e_b_reg       <= PT_RGB[seg + POINT_W'(1)];
            e_ovr_reg     <= |d1_side;
            e_ovr_col_reg <= ovr_col;
            for (int c = 0; c < 3; c++)
            begin
                f_pa_reg[c] <= e_a_reg[(2-c)*COLOR_W +: COLOR_W] * (e_d_reg - e_t_reg);
                f_pb_reg[c] <= e_b_reg[(2-c)*COLOR_W +: COLOR_W] * e_t_reg;
            end
            f_d_reg       <= e_d_reg;
            f_ovr_reg     <= e_ovr_reg;
            f_ovr_col_reg <= e_ovr_col_reg;
        end
    end

    // Interpolation divider: three channels over the segment length
    logic [F:0]       d2_rem  [3];
    logic [COLOR_W-1:0] d2_bits [3];
    logic [COLOR_W-1:0] d2_quot [3];
    logic [N_W-1:0]   d2_num  [3];
    logic [3*COLOR_W:0] d2_side;
    logic             d2_valid;

    always_comb
    begin
        logic [PA_W-1:0] sum;
        for (int c = 0; c < 3; c++)
        begin
            sum       = f_pa_reg[c] + f_pb_reg[c];
            d2_num[c] = sum[N_W-1:0];
            d2_rem[c] = {1'b0, d2_num[c][N_W-1:COLOR_W]};
            d2_bits[c] = d2_num[c][COLOR_W-1:0];
        end
    end

    plcm_div #(
        .LANES(3), .DW(F + 1), .STEPS(COLOR_W), .SIDE_W(3*COLOR_W + 1)
    ) u_mix_div (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(f_valid_reg), .in_rem(d2_rem), .in_bits(d2_bits),
        .in_divisor(f_d_reg), .in_side({f_ovr_reg, f_ovr_col_reg}),
        .out_valid(d2_valid), .out_quot(d2_quot), .out_side(d2_side)
    );

    // Output register
    logic [7:0] red_reg;
    logic [7:0] green_reg;
    logic [7:0] blue_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            red_reg   <= d2_side[3*COLOR_W] ? d2_side[23:16] : d2_quot[0];
            green_reg <= d2_side[3*COLOR_W] ? d2_side[15:8]  : d2_quot[1];
            blue_reg  <= d2_side[3*COLOR_W] ? d2_side[7:0]   : d2_quot[2];
        end
    end

    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

endmodule

[hdl/plcm_checker.sv]
// Port-level checks for the piecewise-linear color map, bound to the top level.
// Depends only on the top level's ports.
module plcm_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] red,
    input logic [7:0] green,
    input logic [7:0] blue
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("output word dropped while stalled");

    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(red) && $stable(green) && $stable(blue))
        else $error("stalled output word changed");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input refused with an empty output register");

    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input taken while the pipeline is frozen");

endmodule

bind piecewise_linear_color_map plcm_checker u_plcm_checker (.*);
